### rtl/uera_pkg.sv
// shared types and constants for the echo ranger with moving average
// no dependencies; compiled first
package uera_pkg;

  localparam int TS_W       = 32;
  localparam int TEMP_W     = 12;
  localparam int PHASE_W    = 3;
  localparam int AVG_W      = 10;
  localparam int SLOPE_W    = 29;
  localparam int FACTOR_W   = 28;
  localparam int PROD_W     = TS_W + FACTOR_W;
  localparam int FACTOR_SHIFT = 33;
  localparam int DIST_W     = PROD_W - FACTOR_SHIFT;

  localparam logic [FACTOR_W-1:0] FACTOR_BASE  = 28'd256108888;
  localparam logic [16:0]         FACTOR_SLOPE = 17'd121907;
  localparam logic [TEMP_W-1:0]   TEMP_RESET   = 12'd889;

  localparam int AVERAGE_DEPTH_DEF  = 5;
  localparam int DISTANCE_LIMIT_DEF = 999;

  typedef enum logic [PHASE_W-1:0] {
    PH_START   = 3'd0,
    PH_POWERUP = 3'd1,
    PH_READY   = 3'd2,
    PH_LISTEN  = 3'd3,
    PH_DETECT  = 3'd4,
    PH_QUIET   = 3'd5
  } phase_t;

  typedef struct packed {
    logic capture_start;
    logic capture_end;
    logic start_meas;
    logic load_factor;
    logic load_prod;
    logic push;
    logic div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic             div_last;
    logic             over_limit;
    logic [AVG_W-1:0] average;
  } dp_status_t;

endpackage

### rtl/uera_in_if.sv
// event request channel: timer tick or echo edge with timestamp
// depends on uera_pkg
interface uera_in_if import uera_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            mode;
  logic            echo_level;
  logic [TS_W-1:0] timestamp;

  modport source (output valid, mode, echo_level, timestamp, input ready);
  modport sink   (input valid, mode, echo_level, timestamp, output ready);
endinterface

### rtl/uera_out_if.sv
// result request channel: phase, flags and averaged distance
// depends on uera_pkg
interface uera_out_if import uera_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] phase;
  logic               trigger_request;
  logic               measurement_valid;
  logic               no_detection;
  logic [AVG_W-1:0]   mean_range;

  modport source (output valid, phase, trigger_request, measurement_valid,
                  no_detection, mean_range, input ready);
  modport sink   (input valid, phase, trigger_request, measurement_valid,
                  no_detection, mean_range, output ready);
endinterface

### rtl/uera_cfg_if.sv
// configuration write channel for the temperature code
// depends on uera_pkg
interface uera_cfg_if import uera_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature_code;

  modport source (output valid, temperature_code, input ready);
  modport sink   (input valid, temperature_code, output ready);
endinterface

### rtl/uera_dp.sv
// datapath: echo times, temperature factor, multiply, distance ring,
// running sum and radix-16 divider; depends on uera_pkg
module uera_dp
  import uera_pkg::*;
#(
  parameter int AVERAGE_DEPTH  = AVERAGE_DEPTH_DEF,
  parameter int DISTANCE_LIMIT = DISTANCE_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TS_W-1:0]   timestamp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TEMP_W-1:0] cfg_temperature_code,
  input  dp_cmd_t           cmd,
  output dp_status_t        status
);

  localparam int SUM_W     = DIST_W + $clog2(AVERAGE_DEPTH);
  localparam int CNT_W     = $clog2(AVERAGE_DEPTH + 1);
  localparam int SLOT_W    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int DIV_R     = 4;
  localparam int DIV_STEPS = (SUM_W + DIV_R - 1) / DIV_R;
  localparam int DIV_W     = DIV_STEPS * DIV_R;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic [TEMP_W-1:0]   temp_r;
  logic [TS_W-1:0]     echo_start_r;
  logic [TS_W-1:0]     echo_end_r;
  logic [TS_W-1:0]     width_r;
  logic [SLOPE_W-1:0]  slope_r;
  logic [FACTOR_W-1:0] factor_r;
  logic [PROD_W-1:0]   prod_r;
  logic [DIST_W-1:0]   ring_r [AVERAGE_DEPTH];
  logic [SLOT_W-1:0]   slot_r;
  logic [CNT_W-1:0]    filled_r;
  logic [SUM_W-1:0]    sum_r;
  logic [DIV_W-1:0]    dvd_r;
  logic [CNT_W-1:0]    rem_r;
  logic [STEP_W-1:0]   step_r;

  logic [DIST_W-1:0]   dist_cm;
  logic [DIST_W-1:0]   old_entry;
  logic [SUM_W-1:0]    sum_nxt;
  logic [DIV_W-1:0]    dvd_nxt;
  logic [CNT_W-1:0]    rem_nxt;
  logic [SUM_W-1:0]    quot;

  assign cfg_ready = 1'b1;

  assign dist_cm   = prod_r[PROD_W-1:FACTOR_SHIFT];
  // entries beyond the fill count have never been written and count as zero
  assign old_entry = (filled_r == CNT_W'(AVERAGE_DEPTH)) ? ring_r[slot_r] : '0;
  assign sum_nxt   = sum_r - SUM_W'(old_entry) + SUM_W'(dist_cm);

  // four restoring division steps per cycle, quotient shifts into dvd
  always_comb begin
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] r;
    logic [DIV_W-1:0] d;
    r = rem_r;
    d = dvd_r;
    for (int k = 0; k < DIV_R; k++) begin
      trial = {r, d[DIV_W-1]};
      d = {d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, filled_r}) begin
        trial = trial - {1'b0, filled_r};
        d[0] = 1'b1;
      end
      r = trial[CNT_W-1:0];
    end
    dvd_nxt = d;
    rem_nxt = r;
  end

  assign quot              = dvd_r[SUM_W-1:0];
  assign status.div_last   = (step_r == '0);
  assign status.over_limit = (quot > SUM_W'(DISTANCE_LIMIT));
  assign status.average    = status.over_limit ? AVG_W'(DISTANCE_LIMIT) : quot[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r       <= TEMP_RESET;
      echo_start_r <= '0;
      echo_end_r   <= '0;
      slot_r       <= '0;
      filled_r     <= '0;
      sum_r        <= '0;
      step_r       <= '0;
    end else begin
      if (cfg_valid) begin
        temp_r <= cfg_temperature_code;
      end
      if (cmd.capture_start) begin
        echo_start_r <= timestamp;
      end
      if (cmd.capture_end) begin
        echo_end_r <= timestamp;
      end
      if (cmd.push) begin
        sum_r  <= sum_nxt;
        slot_r <= (slot_r == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (filled_r != CNT_W'(AVERAGE_DEPTH)) begin
          filled_r <= filled_r + 1'b1;
        end
        step_r <= STEP_W'(DIV_STEPS - 1);
      end else if (cmd.div_step && step_r != '0) begin
        step_r <= step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_meas) begin
      width_r <= echo_end_r - echo_start_r;
      slope_r <= SLOPE_W'(FACTOR_SLOPE) * SLOPE_W'(temp_r);
    end
    if (cmd.load_factor) begin
      // hot enough to drive the factor negative clamps it to zero
      factor_r <= (slope_r >= SLOPE_W'(FACTOR_BASE)) ? '0
                : FACTOR_BASE - slope_r[FACTOR_W-1:0];
    end
    if (cmd.load_prod) begin
      prod_r <= PROD_W'(width_r) * PROD_W'(factor_r);
    end
    if (cmd.push) begin
      ring_r[slot_r] <= dist_cm;
      dvd_r          <= DIV_W'(sum_nxt);
      rem_r          <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

### rtl/uera_ctrl.sv
// controller: ranging phase sequencer, measurement sequencing and
// the result register; depends on uera_pkg
module uera_ctrl
  import uera_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic               in_echo_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PHASE_W-1:0] out_phase,
  output logic               out_trigger_request,
  output logic               out_measurement_valid,
  output logic               out_no_detection,
  output logic [AVG_W-1:0]   out_mean_range,
  output dp_cmd_t            cmd,
  input  dp_status_t         status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FACTOR,
    S_MULT,
    S_PUSH,
    S_DIV,
    S_DONE
  } state_t;

  state_t           state_r;
  phase_t           phase_r;
  logic             trig_r;
  logic             meas_r;
  logic             nodet_r;
  logic             out_valid_r;
  phase_t           out_phase_r;
  logic             out_trig_r;
  logic             out_meas_r;
  logic             out_nodet_r;
  logic [AVG_W-1:0] out_avg_r;

  logic accept;
  logic slot_free;
  logic load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign load_out  = (state_r == S_DONE) && slot_free;

  assign out_valid             = out_valid_r;
  assign out_phase             = out_phase_r;
  assign out_trigger_request   = out_trig_r;
  assign out_measurement_valid = out_meas_r;
  assign out_no_detection      = out_nodet_r;
  assign out_mean_range        = out_avg_r;

  always_comb begin
    cmd               = '0;
    cmd.capture_start = accept && in_mode && in_echo_level;
    cmd.capture_end   = accept && in_mode && !in_echo_level;
    cmd.start_meas    = accept && !in_mode && (phase_r == PH_DETECT);
    cmd.load_factor   = (state_r == S_FACTOR);
    cmd.load_prod     = (state_r == S_MULT);
    cmd.push          = (state_r == S_PUSH);
    cmd.div_step      = (state_r == S_DIV);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_START;
      trig_r      <= 1'b0;
      meas_r      <= 1'b0;
      nodet_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_phase_r <= PH_START;
      out_trig_r  <= 1'b0;
      out_meas_r  <= 1'b0;
      out_nodet_r <= 1'b0;
      out_avg_r   <= '0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            trig_r  <= 1'b0;
            meas_r  <= 1'b0;
            nodet_r <= 1'b0;
            state_r <= S_DONE;
            if (in_mode) begin
              phase_r <= in_echo_level ? PH_LISTEN : PH_DETECT;
            end else begin
              case (phase_r) inside
                PH_START, PH_POWERUP, PH_QUIET: begin
                  phase_r <= PH_READY;
                  trig_r  <= 1'b1;
                end
                PH_LISTEN: begin
                  phase_r <= PH_QUIET;
                  nodet_r <= 1'b1;
                end
                PH_DETECT: begin
                  phase_r <= PH_QUIET;
                  meas_r  <= 1'b1;
                  state_r <= S_FACTOR;
                end
                default: begin
                  phase_r <= phase_r;
                end
              endcase
            end
          end
        end
        S_FACTOR: state_r <= S_MULT;
        S_MULT:   state_r <= S_PUSH;
        S_PUSH:   state_r <= S_DIV;
        S_DIV: begin
          if (status.div_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_phase_r <= phase_r;
            out_trig_r  <= trig_r;
            out_meas_r  <= meas_r;
            out_nodet_r <= nodet_r || (meas_r && status.over_limit);
            out_avg_r   <= meas_r ? status.average : '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_meas_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_meas_r |-> out_phase_r == PH_QUIET)
    else $error("measurement reported outside quiescent phase");

  a_trig_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_trig_r |-> out_phase_r == PH_READY && !out_nodet_r)
    else $error("trigger request without entering ready");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && status.div_last |=> state_r == S_DONE)
    else $error("divider finished but result not staged");

  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_meas_r |-> out_avg_r == '0)
    else $error("average reported without a measurement");

endmodule

### rtl/ultrasonic_echo_ranger_averager.sv
// ultrasonic echo ranger with moving average, top level
// sequence: edges and non-measuring ticks pass straight to the done state, which loads
// the result register; a measuring tick first steps through factor, multiply, push and
// the radix-16 divide loop that forms the average
// one request at a time: a new one is taken only after the last result is loaded
// reset: synchronous active low, phase start, ring empty, temperature code 889
module ultrasonic_echo_ranger_averager
  import uera_pkg::*;
#(
  parameter int AVERAGE_DEPTH  = AVERAGE_DEPTH_DEF,
  parameter int DISTANCE_LIMIT = DISTANCE_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  uera_in_if.sink   in_chan,
  uera_out_if.source out_chan,
  uera_cfg_if.sink  cfg_chan
);

  dp_cmd_t    cmd;
  dp_status_t status;

  uera_ctrl u_ctrl (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_chan.valid),
    .in_ready              (in_chan.ready),
    .in_mode               (in_chan.mode),
    .in_echo_level         (in_chan.echo_level),
    .out_valid             (out_chan.valid),
    .out_ready             (out_chan.ready),
    .out_phase             (out_chan.phase),
    .out_trigger_request   (out_chan.trigger_request),
    .out_measurement_valid (out_chan.measurement_valid),
    .out_no_detection      (out_chan.no_detection),
    .out_mean_range        (out_chan.mean_range),
    .cmd                   (cmd),
    .status                (status)
  );

  uera_dp #(
    .AVERAGE_DEPTH  (AVERAGE_DEPTH),
    .DISTANCE_LIMIT (DISTANCE_LIMIT)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .timestamp            (in_chan.timestamp),
    .cfg_valid            (cfg_chan.valid),
    .cfg_ready            (cfg_chan.ready),
    .cfg_temperature_code (cfg_chan.temperature_code),
    .cmd                  (cmd),
    .status               (status)
  );

endmodule
